/* design/acr_pkg.sv */
package acr_pkg;

    // Default number of byte values that take part in the alphabet
    localparam int ALPHABET_ENTRIES_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 9;
    localparam int OP_W    = 2;

    // Item kinds carried on s_tuser
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN   = 2'd1;
    localparam logic [OP_W-1:0] OP_FORWARD = 2'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

endpackage

/* design/alphabet_compaction_remap.sv */
// A clear word loads its result register on acceptance; learn, forward and reverse
// words first go through the table read, then wait until the result register is free.
// s_tready is low outside the idle state, so no word is taken until the last one is
// through; a clear also holds it low through the table wipe, a learn word with tlast
// through the code sweep. Reset (rst_n, asynchronous, active low): only byte 0 is known,
// as code 0; the table wipe then holds s_tready low before the first word.
module alphabet_compaction_remap #(
    parameter int ALPHABET_ENTRIES = acr_pkg::ALPHABET_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        s_tlast,   // run_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] mapped_value, [16:8] alphabet_count, rest zero
    output logic        m_tuser    // [0] unknown
);

    localparam int ADDR_W = $clog2(ALPHABET_ENTRIES);
    localparam int CW     = acr_pkg::COUNT_W;
    localparam int BW     = acr_pkg::BYTE_W;
    localparam logic [CW-1:0] ENTRIES_C = CW'(ALPHABET_ENTRIES);
    localparam logic [CW-1:0] LAST_C    = CW'(ALPHABET_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEARN = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_PASS  = 3'd3;
    localparam logic [2:0] ST_WIPE  = 3'd4;

    // One byte table entry: seen flag, mapped flag and the code of the byte
    typedef struct packed {
        logic          seen;
        logic          mapped;
        logic [BW-1:0] code;
    } byte_entry_t;

    localparam int ENTRY_W = $bits(byte_entry_t);

    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               seen_total_reg, seen_total_next;
    logic [CW-1:0]               assigned_total_reg, assigned_total_next;
    logic [CW-1:0]               sweep_ctr_reg, sweep_ctr_next;
    logic [CW-1:0]               code_ctr_reg, code_ctr_next;
    logic [acr_pkg::OP_W-1:0]    op_reg;
    logic [BW-1:0]               key_reg;
    logic                        last_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [BW-1:0]               out_value_reg, out_value_next;
    logic                        out_unknown_reg, out_unknown_next;
    logic [CW-1:0]               out_count_reg, out_count_next;

    logic              in_take;
    logic              out_free;
    logic              out_load;
    logic              key_in_range;
    logic              reg_in_range;
    logic [ADDR_W-1:0] key_addr;
    logic [ADDR_W-1:0] reg_addr;
    logic [ADDR_W-1:0] sweep_addr;
    logic [CW-1:0]     prev_ctr;
    logic [ADDR_W-1:0] prev_addr;
    logic              sweep_issue;
    logic              sweep_check;
    logic              read_take;
    logic              byte_wr_en;
    logic [ADDR_W-1:0] byte_wr_addr;
    byte_entry_t       byte_wr_data;
    byte_entry_t       byte_rd;
    logic              rev_wr_en;
    logic [BW-1:0]     rev_rd;

    assign out_free     = !out_valid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE) && out_free;
    assign in_take      = s_tvalid && s_tready;
    assign key_in_range = {1'b0, s_tdata} < ENTRIES_C;
    assign reg_in_range = {1'b0, key_reg} < ENTRIES_C;
    assign key_addr     = s_tdata[ADDR_W-1:0];
    assign reg_addr     = key_reg[ADDR_W-1:0];
    assign sweep_addr   = sweep_ctr_reg[ADDR_W-1:0];
    assign prev_ctr     = sweep_ctr_reg - CW'(1);
    assign prev_addr    = prev_ctr[ADDR_W-1:0];
    // The sweep reads one byte ahead and checks the previous one
    assign sweep_issue  = (state_reg == ST_PASS) && (sweep_ctr_reg != ENTRIES_C);
    assign sweep_check  = (state_reg == ST_PASS) && (sweep_ctr_reg != '0);
    assign read_take    = in_take && (s_tuser != acr_pkg::OP_CLEAR);

    // Byte table: seen flag, mapped flag and code of each byte
    acr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET_ENTRIES)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_wr_addr),
        .wr_data (byte_wr_data),
        .rd_en   (read_take || sweep_issue),
        .rd_addr (sweep_issue ? sweep_addr : key_addr),
        .rd_data (byte_rd)
    );

    // Code to byte table, written by the assignment sweep
    acr_ram #(
        .WIDTH (BW),
        .DEPTH (ALPHABET_ENTRIES)
    ) u_rev_ram (
        .clk     (clk),
        .wr_en   (rev_wr_en),
        .wr_addr (code_ctr_reg[ADDR_W-1:0]),
        .wr_data (prev_ctr[BW-1:0]),
        .rd_en   (read_take),
        .rd_addr (key_addr),
        .rd_data (rev_rd)
    );

    // Sequence items, the sweeps and the result register
    always_comb
    begin
        state_next          = state_reg;
        seen_total_next     = seen_total_reg;
        assigned_total_next = assigned_total_reg;
        sweep_ctr_next      = sweep_ctr_reg;
        code_ctr_next       = code_ctr_reg;
        out_load            = 1'b0;
        out_value_next      = out_value_reg;
        out_unknown_next    = out_unknown_reg;
        out_count_next      = out_count_reg;
        byte_wr_en          = 1'b0;
        byte_wr_addr        = sweep_addr;
        byte_wr_data        = '0;
        rev_wr_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (s_tuser)
                        acr_pkg::OP_CLEAR:
                        begin
                            seen_total_next     = CW'(1);
                            assigned_total_next = CW'(1);
                            out_load            = 1'b1;
                            out_value_next      = '0;
                            out_unknown_next    = 1'b0;
                            out_count_next      = CW'(1);
                            sweep_ctr_next      = '0;
                            state_next          = ST_WIPE;
                        end
                        acr_pkg::OP_LEARN:
                        begin
                            state_next = ST_LEARN;
                        end
                        default:
                        begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_LEARN:
            begin
                // Mark the byte seen once the result register is free
                if (out_free)
                begin
                    if (reg_in_range && !byte_rd.seen)
                    begin
                        byte_wr_en        = 1'b1;
                        byte_wr_addr      = reg_addr;
                        byte_wr_data      = byte_rd;
                        byte_wr_data.seen = 1'b1;
                        seen_total_next   = seen_total_reg + CW'(1);
                    end
                    out_load         = 1'b1;
                    out_value_next   = '0;
                    out_unknown_next = 1'b0;
                    out_count_next   = seen_total_next;
                    if (last_reg)
                    begin
                        sweep_ctr_next = '0;
                        code_ctr_next  = '0;
                        state_next     = ST_PASS;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                // Finish the lookup once the result register is free
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_count_next   = seen_total_reg;
                    out_value_next   = '0;
                    out_unknown_next = 1'b0;
                    if (op_reg == acr_pkg::OP_FORWARD)
                    begin
                        if (reg_in_range && byte_rd.mapped)
                        begin
                            out_value_next = byte_rd.code;
                        end
                        else
                        begin
                            out_unknown_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if ({1'b0, key_reg} >= assigned_total_reg)
                        begin
                            out_unknown_next = 1'b1;
                        end
                        else if (key_reg != '0)
                        begin
                            out_value_next = rev_rd;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_PASS:
            begin
                // Give the next code to each seen byte, ascending
                if (sweep_check && byte_rd.seen)
                begin
                    byte_wr_en          = 1'b1;
                    byte_wr_addr        = prev_addr;
                    byte_wr_data.seen   = 1'b1;
                    byte_wr_data.mapped = 1'b1;
                    byte_wr_data.code   = code_ctr_reg[BW-1:0];
                    rev_wr_en           = 1'b1;
                    code_ctr_next       = code_ctr_reg + CW'(1);
                end
                if (sweep_ctr_reg == ENTRIES_C)
                begin
                    assigned_total_next = code_ctr_next;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    sweep_ctr_next = sweep_ctr_reg + CW'(1);
                end
            end
            ST_WIPE:
            begin
                // Clear every byte entry, leaving byte 0 known as code 0
                byte_wr_en = 1'b1;
                if (sweep_ctr_reg == '0)
                begin
                    byte_wr_data.seen   = 1'b1;
                    byte_wr_data.mapped = 1'b1;
                end
                sweep_ctr_next = sweep_ctr_reg + CW'(1);
                if (sweep_ctr_reg == LAST_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_WIPE;
            seen_total_reg     <= CW'(1);
            assigned_total_reg <= CW'(1);
            sweep_ctr_reg      <= '0;
            code_ctr_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            seen_total_reg     <= seen_total_next;
            assigned_total_reg <= assigned_total_next;
            sweep_ctr_reg      <= sweep_ctr_next;
            code_ctr_reg       <= code_ctr_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload: hold the word under lookup and the result
    always_ff @(posedge clk)
    begin
        if (read_take)
        begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        out_value_reg   <= out_value_next;
        out_unknown_reg <= out_unknown_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_value_reg};
    assign m_tuser  = out_unknown_reg;

`ifndef SYNTHESIS
    // No word enters outside the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("word accepted while busy");

    // Codes handed out never exceed bytes seen
    assert property (@(posedge clk) disable iff (!rst_n)
        assigned_total_reg <= seen_total_reg)
        else $error("assigned total above seen total");

    // Sweep counter stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_ctr_reg <= ENTRIES_C)
        else $error("sweep counter out of range");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");
`endif

endmodule

/* design/acr_ram.sv */
module acr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
